// ===== src/cfa_pkg.sv =====
`default_nettype none
package cfa_pkg;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int STRAT_W  = 2;
    localparam int OWNER_W  = 16;
    localparam int SIZE_W   = 21;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 20;
    localparam int LEN_W    = 21;

    // Default configuration
    localparam int DEF_SPACE_UNITS  = 1048576;
    localparam int DEF_MAX_SEGMENTS = 16;
    localparam int DEF_MAX_HOLES    = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPACT = 2'd2;

    // Strategy codes
    localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
    localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
    localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // Datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP   = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
    localparam logic [OP_W-1:0] OP_SCAN  = 4'd2;
    localparam logic [OP_W-1:0] OP_CARVE = 4'd3;
    localparam logic [OP_W-1:0] OP_HDN   = 4'd4;
    localparam logic [OP_W-1:0] OP_SFIND = 4'd5;
    localparam logic [OP_W-1:0] OP_SUP   = 4'd6;
    localparam logic [OP_W-1:0] OP_RFIND = 4'd7;
    localparam logic [OP_W-1:0] OP_SDN   = 4'd8;
    localparam logic [OP_W-1:0] OP_HFIND = 4'd9;
    localparam logic [OP_W-1:0] OP_HUP   = 4'd10;
    localparam logic [OP_W-1:0] OP_CSEG  = 4'd11;
    localparam logic [OP_W-1:0] OP_RES   = 4'd12;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [STATUS_W-1:0] res_status;
        logic                use_base;
        logic                use_free;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             seg_full;
        logic             hole_full;
        logic             bad_req;
        logic             scan_done;
        logic             found;
        logic             carve_empty;
        logic             hdn_done;
        logic             sfind_done;
        logic             sup_done;
        logic             rfind_done;
        logic             rfound;
        logic             sdn_done;
        logic             hfind_done;
        logic             hup_done;
        logic             cseg_done;
        logic             out_busy;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== src/cfa_if.sv =====
`default_nettype none
interface cfa_in_if;
    logic                         valid;
    logic                         ready;
    logic [cfa_pkg::CMD_W-1:0]    command;
    logic [cfa_pkg::STRAT_W-1:0]  strategy;
    logic [cfa_pkg::OWNER_W-1:0]  owner_id;
    logic [cfa_pkg::SIZE_W-1:0]   request_size;
    modport source (output valid, command, strategy, owner_id, request_size, input ready);
    modport sink   (input valid, command, strategy, owner_id, request_size, output ready);
endinterface

interface cfa_out_if;
    logic                          valid;
    logic                          ready;
    logic [cfa_pkg::STATUS_W-1:0]  status;
    logic [cfa_pkg::ADDR_W-1:0]    base_address;
    logic [cfa_pkg::LEN_W-1:0]     free_end;
    modport source (output valid, status, base_address, free_end, input ready);
    modport sink   (input valid, status, base_address, free_end, output ready);
endinterface
`default_nettype wire

// ===== src/cfa_ctrl.sv =====
`default_nettype none
module cfa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire cfa_pkg::t_dp_stat i_stat,
    output cfa_pkg::t_dp_cmd       o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_CARVE = 4'd3;
    localparam logic [3:0] S_HDN   = 4'd4;
    localparam logic [3:0] S_SFIND = 4'd5;
    localparam logic [3:0] S_SUP   = 4'd6;
    localparam logic [3:0] S_RFIND = 4'd7;
    localparam logic [3:0] S_SDN   = 4'd8;
    localparam logic [3:0] S_HFIND = 4'd9;
    localparam logic [3:0] S_HUP   = 4'd10;
    localparam logic [3:0] S_CSEG  = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0]                   r_state, n_state;
    logic [cfa_pkg::STATUS_W-1:0] r_res, n_res;
    logic                         r_ubase, n_ubase;
    logic                         r_ufree, n_ufree;

    // Sequence the datapath through each command
    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        n_ubase = r_ubase;
        n_ufree = r_ufree;
        o_cmd.op         = cfa_pkg::OP_NOP;
        o_cmd.res_status = r_res;
        o_cmd.use_base   = r_ubase;
        o_cmd.use_free   = r_ufree;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = cfa_pkg::OP_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                n_res   = cfa_pkg::ST_OK;
                n_ubase = 1'b0;
                n_ufree = 1'b0;
                case (i_stat.cmd)
                    cfa_pkg::CMD_REQUEST: begin
                        if (i_stat.seg_full) begin
                            n_res   = cfa_pkg::ST_FULL;
                            n_state = S_DONE;
                        end else if (i_stat.bad_req) begin
                            n_res   = cfa_pkg::ST_NO_FIT;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    cfa_pkg::CMD_RELEASE: n_state = S_RFIND;
                    cfa_pkg::CMD_COMPACT: n_state = S_CSEG;
                    default:              n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                o_cmd.op = cfa_pkg::OP_SCAN;
                if (i_stat.scan_done) begin
                    if (i_stat.found) begin
                        n_state = S_CARVE;
                    end else begin
                        n_res   = cfa_pkg::ST_NO_FIT;
                        n_state = S_DONE;
                    end
                end
            end
            S_CARVE: begin
                o_cmd.op = cfa_pkg::OP_CARVE;
                n_state  = i_stat.carve_empty ? S_HDN : S_SFIND;
            end
            S_HDN: begin
                o_cmd.op = cfa_pkg::OP_HDN;
                if (i_stat.hdn_done) n_state = S_SFIND;
            end
            S_SFIND: begin
                o_cmd.op = cfa_pkg::OP_SFIND;
                if (i_stat.sfind_done) n_state = S_SUP;
            end
            S_SUP: begin
                o_cmd.op = cfa_pkg::OP_SUP;
                if (i_stat.sup_done) begin
                    n_ubase = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_RFIND: begin
                o_cmd.op = cfa_pkg::OP_RFIND;
                if (i_stat.rfind_done) begin
                    if (!i_stat.rfound) begin
                        n_res   = cfa_pkg::ST_NOT_FOUND;
                        n_state = S_DONE;
                    end else if (i_stat.hole_full) begin
                        n_res   = cfa_pkg::ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SDN;
                    end
                end
            end
            S_SDN: begin
                o_cmd.op = cfa_pkg::OP_SDN;
                if (i_stat.sdn_done) n_state = S_HFIND;
            end
            S_HFIND: begin
                o_cmd.op = cfa_pkg::OP_HFIND;
                if (i_stat.hfind_done) n_state = S_HUP;
            end
            S_HUP: begin
                o_cmd.op = cfa_pkg::OP_HUP;
                if (i_stat.hup_done) begin
                    n_ubase = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_CSEG: begin
                o_cmd.op = cfa_pkg::OP_CSEG;
                if (i_stat.cseg_done) begin
                    n_ufree = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold until the result register is free
                if (!i_stat.out_busy) begin
                    o_cmd.op = cfa_pkg::OP_RES;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res   <= cfa_pkg::ST_OK;
            r_ubase <= 1'b0;
            r_ufree <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
            r_ubase <= n_ubase;
            r_ufree <= n_ufree;
        end
    end
endmodule
`default_nettype wire

// ===== src/cfa_datapath.sv =====
`default_nettype none
module cfa_datapath #(
    parameter int SPACE_UNITS  = cfa_pkg::DEF_SPACE_UNITS,
    parameter int MAX_SEGMENTS = cfa_pkg::DEF_MAX_SEGMENTS,
    parameter int MAX_HOLES    = cfa_pkg::DEF_MAX_HOLES
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    cfa_in_if.sink                i_in,
    cfa_out_if.source             o_out,
    input  wire cfa_pkg::t_dp_cmd i_cmd,
    output cfa_pkg::t_dp_stat     o_stat
);
    localparam int AW  = cfa_pkg::ADDR_W;
    localparam int LW  = cfa_pkg::LEN_W;
    localparam int SCW = $clog2(MAX_SEGMENTS + 1);
    localparam int HCW = $clog2(MAX_HOLES + 1);
    localparam int IW  = (SCW > HCW) ? SCW : HCW;
    localparam int SIW = $clog2(MAX_SEGMENTS);
    localparam int HIW = $clog2(MAX_HOLES);
    localparam logic [LW-1:0] SPACE = LW'(SPACE_UNITS);

    // Tables
    logic [AW-1:0]                r_ss [MAX_SEGMENTS];
    logic [LW-1:0]                r_sl [MAX_SEGMENTS];
    logic [cfa_pkg::OWNER_W-1:0]  r_so [MAX_SEGMENTS];
    logic [LW-1:0]                r_hs [MAX_HOLES];
    logic [LW-1:0]                r_hl [MAX_HOLES];
    logic [SCW-1:0]               r_ns;
    logic [HCW-1:0]               r_nh;

    // Working registers
    logic [cfa_pkg::CMD_W-1:0]    r_cmd;
    logic [cfa_pkg::STRAT_W-1:0]  r_strat;
    logic [cfa_pkg::OWNER_W-1:0]  r_owner;
    logic [cfa_pkg::SIZE_W-1:0]   r_size;
    logic [IW-1:0]                r_idx, r_kdx;
    logic [HIW-1:0]               r_pick;
    logic [LW-1:0]                r_best;
    logic                         r_found;
    logic [AW-1:0]                r_base;
    logic [LW-1:0]                r_len;
    logic [LW-1:0]                r_run;

    // Result register
    logic                         r_ov;
    logic [cfa_pkg::STATUS_W-1:0] r_ost;
    logic [AW-1:0]                r_obase;
    logic [LW-1:0]                r_ofree;

    logic [IW-1:0]  w_idx1, w_kdx1, w_ns, w_nh;
    logic [SIW-1:0] w_si, w_si1, w_sk, w_sk1;
    logic [HIW-1:0] w_hi, w_hi1, w_hk, w_hk1;
    logic [LW-1:0]  w_len;
    logic           w_fit, w_better;
    logic           w_sin, w_hin;

    assign w_idx1 = r_idx + 1'b1;
    assign w_kdx1 = r_kdx - 1'b1;
    assign w_ns   = IW'(r_ns);
    assign w_nh   = IW'(r_nh);
    assign w_si   = r_idx[SIW-1:0];
    assign w_si1  = w_idx1[SIW-1:0];
    assign w_sk   = r_kdx[SIW-1:0];
    assign w_sk1  = w_kdx1[SIW-1:0];
    assign w_hi   = r_idx[HIW-1:0];
    assign w_hi1  = w_idx1[HIW-1:0];
    assign w_hk   = r_kdx[HIW-1:0];
    assign w_hk1  = w_kdx1[HIW-1:0];
    assign w_sin  = (r_idx < w_ns);
    assign w_hin  = (r_idx < w_nh);

    // Fit test for the scanned hole
    assign w_len    = r_hl[w_hi];
    assign w_fit    = (w_len >= r_size);
    assign w_better = !r_found ||
                      ((r_strat == cfa_pkg::STRAT_BEST) ? (w_len <= r_best) : (w_len >= r_best));

    // Status toward the controller
    always_comb begin
        o_stat.cmd         = r_cmd;
        o_stat.seg_full    = (r_ns == SCW'(MAX_SEGMENTS));
        o_stat.hole_full   = (r_nh == HCW'(MAX_HOLES));
        o_stat.bad_req     = (r_strat > cfa_pkg::STRAT_WORST) || (r_size == '0);
        o_stat.scan_done   = !w_hin || (r_found && (r_strat == cfa_pkg::STRAT_FIRST));
        o_stat.found       = r_found;
        o_stat.carve_empty = (r_hl[r_pick] == r_size);
        o_stat.hdn_done    = !(w_idx1 < w_nh);
        o_stat.sfind_done  = !(w_sin && (r_ss[w_si] <= r_base));
        o_stat.sup_done    = !(r_kdx > r_idx);
        o_stat.rfind_done  = !(w_sin && (r_so[w_si] != r_owner));
        o_stat.rfound      = w_sin;
        o_stat.sdn_done    = !(w_idx1 < w_ns);
        o_stat.hfind_done  = !(w_hin && (r_hs[w_hi] <= LW'(r_base)));
        o_stat.hup_done    = !(r_kdx > r_idx);
        o_stat.cseg_done   = !w_sin;
        o_stat.out_busy    = r_ov;
    end

    // Accept a command exactly when the controller loads it
    assign i_in.ready         = (i_cmd.op == cfa_pkg::OP_LOAD);
    assign o_out.valid        = r_ov;
    assign o_out.status       = r_ost;
    assign o_out.base_address = r_obase;
    assign o_out.free_end     = r_ofree;

    // Table and working register updates
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            cfa_pkg::OP_LOAD: begin
                r_cmd   <= i_in.command;
                r_strat <= i_in.strategy;
                r_owner <= i_in.owner_id;
                r_size  <= i_in.request_size;
                r_idx   <= '0;
                r_kdx   <= '0;
                r_best  <= '0;
                r_run   <= '0;
            end
            cfa_pkg::OP_SCAN: begin
                if (!o_stat.scan_done) begin
                    if (w_fit && ((r_strat == cfa_pkg::STRAT_FIRST) || w_better)) begin
                        r_pick <= w_hi;
                        r_best <= w_len;
                    end
                    r_idx <= w_idx1;
                end
            end
            cfa_pkg::OP_CARVE: begin
                r_hs[r_pick] <= r_hs[r_pick] + LW'(r_size);
                r_hl[r_pick] <= r_hl[r_pick] - LW'(r_size);
                r_base       <= r_hs[r_pick][AW-1:0];
                r_idx        <= o_stat.carve_empty ? IW'(r_pick) : '0;
            end
            cfa_pkg::OP_HDN: begin
                // Close the gap left by an exhausted hole
                if (!o_stat.hdn_done) begin
                    r_hs[w_hi] <= r_hs[w_hi1];
                    r_hl[w_hi] <= r_hl[w_hi1];
                    r_idx      <= w_idx1;
                end else begin
                    r_idx <= '0;
                end
            end
            cfa_pkg::OP_SFIND: begin
                if (!o_stat.sfind_done) r_idx <= w_idx1;
                else                    r_kdx <= w_ns;
            end
            cfa_pkg::OP_SUP: begin
                // Open a slot, then drop the new segment in
                if (!o_stat.sup_done) begin
                    r_ss[w_sk] <= r_ss[w_sk1];
                    r_sl[w_sk] <= r_sl[w_sk1];
                    r_so[w_sk] <= r_so[w_sk1];
                    r_kdx      <= w_kdx1;
                end else begin
                    r_ss[w_si] <= r_base;
                    r_sl[w_si] <= LW'(r_size);
                    r_so[w_si] <= r_owner;
                end
            end
            cfa_pkg::OP_RFIND: begin
                if (!o_stat.rfind_done) begin
                    r_idx <= w_idx1;
                end else if (w_sin) begin
                    r_base <= r_ss[w_si];
                    r_len  <= r_sl[w_si];
                end
            end
            cfa_pkg::OP_SDN: begin
                if (!o_stat.sdn_done) begin
                    r_ss[w_si] <= r_ss[w_si1];
                    r_sl[w_si] <= r_sl[w_si1];
                    r_so[w_si] <= r_so[w_si1];
                    r_idx      <= w_idx1;
                end else begin
                    r_idx <= '0;
                end
            end
            cfa_pkg::OP_HFIND: begin
                if (!o_stat.hfind_done) r_idx <= w_idx1;
                else                    r_kdx <= w_nh;
            end
            cfa_pkg::OP_HUP: begin
                if (!o_stat.hup_done) begin
                    r_hs[w_hk] <= r_hs[w_hk1];
                    r_hl[w_hk] <= r_hl[w_hk1];
                    r_kdx      <= w_kdx1;
                end else begin
                    r_hs[w_hi] <= LW'(r_base);
                    r_hl[w_hi] <= r_len;
                end
            end
            cfa_pkg::OP_CSEG: begin
                // Slide segments down, then leave at most one trailing hole
                if (w_sin) begin
                    r_ss[w_si] <= r_run[AW-1:0];
                    r_run      <= r_run + r_sl[w_si];
                    r_idx      <= w_idx1;
                end else begin
                    r_hs[0] <= r_run;
                    r_hl[0] <= SPACE - r_run;
                end
            end
            default: ;
        endcase
        if (!i_rst_n) begin
            r_hs[0] <= '0;
            r_hl[0] <= SPACE;
        end
    end

    // Control state: counts, found flag and the result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ns    <= '0;
            r_nh    <= HCW'(1);
            r_found <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) r_ov <= 1'b0;
            case (i_cmd.op)
                cfa_pkg::OP_LOAD: r_found <= 1'b0;
                cfa_pkg::OP_SCAN: begin
                    if (!o_stat.scan_done && w_fit &&
                        ((r_strat == cfa_pkg::STRAT_FIRST) || w_better)) begin
                        r_found <= 1'b1;
                    end
                end
                cfa_pkg::OP_HDN:  if (o_stat.hdn_done) r_nh <= r_nh - 1'b1;
                cfa_pkg::OP_SUP:  if (o_stat.sup_done) r_ns <= r_ns + 1'b1;
                cfa_pkg::OP_SDN:  if (o_stat.sdn_done) r_ns <= r_ns - 1'b1;
                cfa_pkg::OP_HUP:  if (o_stat.hup_done) r_nh <= r_nh + 1'b1;
                cfa_pkg::OP_CSEG: begin
                    if (!w_sin) r_nh <= (r_run < SPACE) ? HCW'(1) : '0;
                end
                cfa_pkg::OP_RES:  r_ov <= 1'b1;
                default: ;
            endcase
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == cfa_pkg::OP_RES) begin
            r_ost   <= i_cmd.res_status;
            r_obase <= i_cmd.use_base ? r_base : '0;
            r_ofree <= i_cmd.use_free ? r_run : '0;
        end
    end
endmodule
`default_nettype wire

// ===== src/contiguous_fit_allocator_core.sv =====
`default_nettype none
// Contiguous fit allocator.
// i_cmd carries one transaction per command: request (size, owner, strategy),
// release by owner, or compact. o_res returns exactly one transaction per
// command with status, base address and free end.
// A request scans the hole table and shifts entries of both tables, a release
// searches and shifts both tables, and a compact slides the segments down.
// The sequencer walks the tables one entry per cycle through a single
// datapath; one command is processed at a time, and i_cmd.ready is
// high only while the block is idle and a command is offered.
// Reset (synchronous, active low) empties the segment table and leaves one
// hole covering the whole space.
// When the receiver stalls, the result register holds its transaction and
// the next command may still be accepted and processed; it waits at its end
// until the result register is taken.
module contiguous_fit_allocator_core #(
    parameter int SPACE_UNITS  = cfa_pkg::DEF_SPACE_UNITS,
    parameter int MAX_SEGMENTS = cfa_pkg::DEF_MAX_SEGMENTS,
    parameter int MAX_HOLES    = cfa_pkg::DEF_MAX_HOLES
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cfa_in_if.sink    i_cmd,
    cfa_out_if.source o_res
);
    cfa_pkg::t_dp_cmd  w_cmd;
    cfa_pkg::t_dp_stat w_stat;

    cfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    cfa_datapath #(
        .SPACE_UNITS  (SPACE_UNITS),
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .MAX_HOLES    (MAX_HOLES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_cmd),
        .o_out   (o_res),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );
endmodule
`default_nettype wire

// ===== src/cfa_checker.sv =====
`default_nettype none
module cfa_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         i_in_ready,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [cfa_pkg::STATUS_W-1:0] i_status,
    input wire logic [cfa_pkg::ADDR_W-1:0]   i_base,
    input wire logic [cfa_pkg::LEN_W-1:0]    i_free
);
    // One command in flight: ready drops after an accepted transaction
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("command accepted while another is in flight");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_status) && $stable(i_base) && $stable(i_free)))
        else $error("stalled result changed");

    // Failed commands report zero address fields
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != cfa_pkg::ST_OK)) |-> (i_base == '0 && i_free == '0))
        else $error("failed command with nonzero address");

    // Reset empties the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind contiguous_fit_allocator_core cfa_checker u_cfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_base      (o_res.base_address),
    .i_free      (o_res.free_end)
);
`default_nettype wire
